// ----- hdl/acir_pkg.sv -----
`timescale 1ns / 1ps

package acir_pkg;

  typedef struct packed {
    logic [15:0] hdr_mark;
    logic [15:0] hdr_space;
    logic [15:0] bit_mark;
    logic [15:0] short_space;
    logic [15:0] long_space;
    logic [15:0] gap;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    REG_HDR_MARK    = 3'd0,
    REG_HDR_SPACE   = 3'd1,
    REG_BIT_MARK    = 3'd2,
    REG_SHORT_SPACE = 3'd3,
    REG_LONG_SPACE  = 3'd4,
    REG_GAP         = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TEMP_REJECT = 2'd1,
    STATUS_BUSY_REJECT = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic [5:0] set_temperature;
    logic       turbo_on;
    logic       sleep_on;
    logic [2:0] horizontal_swing;
    logic [2:0] vertical_swing;
    logic [1:0] fan_speed;
    logic [2:0] op_mode;
    logic       power_on;
  } cmd_t;

  localparam logic [15:0] HDR_MARK_RST    = 16'd9000;
  localparam logic [15:0] HDR_SPACE_RST   = 16'd4500;
  localparam logic [15:0] BIT_MARK_RST    = 16'd620;
  localparam logic [15:0] SHORT_SPACE_RST = 16'd540;
  localparam logic [15:0] LONG_SPACE_RST  = 16'd1600;
  localparam logic [15:0] GAP_RST         = 16'd20000;

  // segment positions within one block
  localparam logic [6:0] POS_HDR_MARK   = 7'd0;
  localparam logic [6:0] POS_HDR_SPACE  = 7'd1;
  localparam logic [6:0] POS_DATA_END   = 7'd66;
  localparam logic [6:0] POS_FOOTER_ONE = 7'd69;
  localparam logic [6:0] POS_GAP        = 7'd73;

  localparam logic [5:0] TEMP_MIN = 6'd16;
  localparam logic [5:0] TEMP_MAX = 6'd30;

  localparam logic [7:0] BYTE2_FIXED = 8'h60;
  localparam logic [7:0] BYTE3_FIXED = 8'h50;
  localparam logic [7:0] BYTE5_FIXED = 8'h20;
  localparam logic [7:0] BYTE6_FIXED = 8'h00;

  function automatic logic [3:0] vcode(input logic [2:0] vs);
    logic [3:0] c;
    unique case (vs)
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h4;
      3'd4:    c = 4'h6;
      3'd5:    c = 4'h6;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] hcode(input logic [2:0] hs);
    logic [3:0] c;
    unique case (hs)
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h3;
      3'd4:    c = 4'h5;
      3'd5:    c = 4'h6;
      default: c = 4'h4;
    endcase
    return c;
  endfunction

  // byte 0 in the lowest bits
  function automatic logic [63:0] build_frame(input cmd_t cmd);
    logic [2:0] mode;
    logic [7:0] b0, b1, b2, b4, b7;
    logic [3:0] sum;
    mode = (cmd.op_mode > 3'd4) ? 3'd0 : cmd.op_mode;
    b0 = {cmd.sleep_on, (cmd.vertical_swing == 3'd1), cmd.fan_speed, cmd.power_on, mode};
    b1 = {2'b00, cmd.set_temperature} - {2'b00, TEMP_MIN};
    b2 = BYTE2_FIXED | {3'b000, cmd.turbo_on, 4'h0};
    b4 = {hcode(cmd.horizontal_swing), vcode(cmd.vertical_swing)};
    sum = b0[3:0] + b1[3:0] + b2[3:0] + BYTE3_FIXED[3:0]
        + b4[7:4] + BYTE5_FIXED[7:4] + BYTE6_FIXED[7:4];
    b7 = {sum, 4'h0};
    return {b7, BYTE6_FIXED, BYTE5_FIXED, b4, BYTE3_FIXED, b2, b1, b0};
  endfunction

endpackage

// ----- hdl/acir_seg_len.sv -----
`timescale 1ns / 1ps

module acir_seg_len
  import acir_pkg::*;
(
  input  logic [6:0]  seg_pos,
  input  logic        seg_blk,
  input  logic [63:0] frame,
  input  cfg_regs_t   regs,
  output logic [15:0] seg_ticks
);

  logic [6:0]  pos_m2;
  logic [5:0]  bit_sel;
  logic        bit_val;
  logic [15:0] len;

  assign pos_m2  = seg_pos - 7'd2;
  assign bit_sel = {seg_blk, pos_m2[5:1]};

  always_comb begin
    bit_val = 1'b0;
    priority if (seg_pos == POS_HDR_MARK) begin
      len = regs.hdr_mark;
    end else if (seg_pos == POS_HDR_SPACE) begin
      len = regs.hdr_space;
    end else if (!seg_pos[0]) begin
      len = regs.bit_mark;
    end else if (seg_pos == POS_GAP) begin
      len = regs.gap;
    end else begin
      if (seg_pos < POS_DATA_END) begin
        bit_val = frame[bit_sel];
      end else begin
        bit_val = (seg_pos == POS_FOOTER_ONE);
      end
      len = bit_val ? regs.long_space : regs.short_space;
    end
  end

  // a zero register still lasts one tick
  assign seg_ticks = (len == 16'd0) ? 16'd1 : len;

endmodule

// ----- hdl/ac_ir_remote_frame_transmitter_unit.sv -----
`timescale 1ns / 1ps
// Air-conditioner IR remote frame transmitter. A load item (tuser 0) checks the temperature
// (16..30), builds the eight-byte frame and starts a transmission; each tick item (tuser 1)
// then returns one level of the carrier envelope: two blocks, each a header mark and space,
// 32 data bits LSB first as mark plus zero- or one-space, a 010 footer, a trailing mark and
// a gap, with segment lengths taken from the timing registers when each segment starts.
// Every item gives exactly one result item; out_tlast marks the last tick of the final gap.
// One item is taken per clock: the item is held in an input register, and its work
// (one counter decrement or one frame build) is done in the cycle it moves to the output
// register, so throughput is one item per cycle while out_tready is high.

module ac_ir_remote_frame_transmitter_unit
  import acir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // power_on[0], op_mode[3:1], fan_speed[5:4], vertical_swing[8:6],
  // horizontal_swing[11:9], sleep_on[12], turbo_on[13], set_temperature[19:14], zero[23:20]
  input  logic [23:0] in_tdata,
  // action[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // carrier_on[0], busy_res[1], status[3:2], zero[7:4]
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_regs_t   regs_r;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  logic        in_valid_r;
  action_t     in_action_r;
  cmd_t        in_cmd_r;
  logic        advance;

  logic [63:0] frame_r, frame_nxt;
  logic [6:0]  seg_pos_r, seg_pos_nxt;
  logic        seg_blk_r, seg_blk_nxt;
  logic [15:0] ticks_left_r, ticks_left_nxt;
  logic        xmit_r, xmit_nxt;

  logic        out_valid_r;
  logic        carrier_r, carrier_nxt;
  logic        busy_r, busy_nxt;
  status_t     status_r, status_nxt;
  logic        fend_r, fend_nxt;

  logic        at_gap;
  logic [6:0]  tick_pos;
  logic        tick_blk;
  logic [6:0]  len_pos;
  logic        len_blk;
  logic [15:0] len_ticks;

  // configuration port
  assign reg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.hdr_mark    <= HDR_MARK_RST;
      regs_r.hdr_space   <= HDR_SPACE_RST;
      regs_r.bit_mark    <= BIT_MARK_RST;
      regs_r.short_space <= SHORT_SPACE_RST;
      regs_r.long_space  <= LONG_SPACE_RST;
      regs_r.gap         <= GAP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HDR_MARK:    regs_r.hdr_mark    <= cfg_pwdata[15:0];
        REG_HDR_SPACE:   regs_r.hdr_space   <= cfg_pwdata[15:0];
        REG_BIT_MARK:    regs_r.bit_mark    <= cfg_pwdata[15:0];
        REG_SHORT_SPACE: regs_r.short_space <= cfg_pwdata[15:0];
        REG_LONG_SPACE:  regs_r.long_space  <= cfg_pwdata[15:0];
        REG_GAP:         regs_r.gap         <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HDR_MARK:    cfg_prdata = {16'h0, regs_r.hdr_mark};
      REG_HDR_SPACE:   cfg_prdata = {16'h0, regs_r.hdr_space};
      REG_BIT_MARK:    cfg_prdata = {16'h0, regs_r.bit_mark};
      REG_SHORT_SPACE: cfg_prdata = {16'h0, regs_r.short_space};
      REG_LONG_SPACE:  cfg_prdata = {16'h0, regs_r.long_space};
      REG_GAP:         cfg_prdata = {16'h0, regs_r.gap};
      default:         cfg_prdata = 32'h0;
    endcase
  end

  // input register
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_action_r <= action_t'(in_tuser);
      in_cmd_r    <= cmd_t'(in_tdata[19:0]);
    end
  end

  // segment sequencing
  assign at_gap   = (seg_pos_r == POS_GAP);
  assign tick_pos = at_gap ? POS_HDR_MARK : seg_pos_r + 7'd1;
  assign tick_blk = seg_blk_r ^ at_gap;
  assign len_pos  = (in_action_r == ACT_TICK) ? tick_pos : POS_HDR_MARK;
  assign len_blk  = (in_action_r == ACT_TICK) ? tick_blk : 1'b0;

  acir_seg_len u_seg_len (
    .seg_pos   (len_pos),
    .seg_blk   (len_blk),
    .frame     (frame_r),
    .regs      (regs_r),
    .seg_ticks (len_ticks)
  );

  always_comb begin
    frame_nxt      = frame_r;
    seg_pos_nxt    = seg_pos_r;
    seg_blk_nxt    = seg_blk_r;
    ticks_left_nxt = ticks_left_r;
    xmit_nxt       = xmit_r;
    carrier_nxt    = 1'b0;
    status_nxt     = STATUS_OK;
    fend_nxt       = 1'b0;
    unique case (in_action_r)
      ACT_LOAD: begin
        priority if (xmit_r) begin
          status_nxt = STATUS_BUSY_REJECT;
        end else if (in_cmd_r.set_temperature < TEMP_MIN ||
                     in_cmd_r.set_temperature > TEMP_MAX) begin
          status_nxt = STATUS_TEMP_REJECT;
        end else begin
          frame_nxt      = build_frame(in_cmd_r);
          seg_pos_nxt    = POS_HDR_MARK;
          seg_blk_nxt    = 1'b0;
          ticks_left_nxt = len_ticks;
          xmit_nxt       = 1'b1;
        end
      end
      ACT_TICK: begin
        if (xmit_r) begin
          carrier_nxt = !seg_pos_r[0];
          if (ticks_left_r <= 16'd1) begin
            if (at_gap && seg_blk_r) begin
              xmit_nxt       = 1'b0;
              seg_pos_nxt    = POS_HDR_MARK;
              seg_blk_nxt    = 1'b0;
              ticks_left_nxt = 16'd0;
              fend_nxt       = 1'b1;
            end else begin
              seg_pos_nxt    = tick_pos;
              seg_blk_nxt    = tick_blk;
              ticks_left_nxt = len_ticks;
            end
          end else begin
            ticks_left_nxt = ticks_left_r - 16'd1;
          end
        end
      end
      default: ;
    endcase
    busy_nxt = xmit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pos_r    <= POS_HDR_MARK;
      seg_blk_r    <= 1'b0;
      ticks_left_r <= 16'd0;
      xmit_r       <= 1'b0;
    end else if (advance) begin
      seg_pos_r    <= seg_pos_nxt;
      seg_blk_r    <= seg_blk_nxt;
      ticks_left_r <= ticks_left_nxt;
      xmit_r       <= xmit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_r   <= frame_nxt;
      carrier_r <= carrier_nxt;
      busy_r    <= busy_nxt;
      status_r  <= status_nxt;
      fend_r    <= fend_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, status_r, busy_r, carrier_r};
  assign out_tlast  = fend_r;

endmodule
